>>> rtl/lcdw_pkg.sv
// Shared types, constants and command/status structs of the character LCD expander writer.
package lcdw_pkg;

  // Request kinds carried in the mode field.
  localparam logic [1:0] MODE_CMD    = 2'd0;
  localparam logic [1:0] MODE_CHAR   = 2'd1;
  localparam logic [1:0] MODE_NUMBER = 2'd2;
  localparam logic [1:0] MODE_CURSOR = 2'd3;

  // Expander bit assignments and display constants.
  localparam logic [7:0] BIT_BACKLIGHT = 8'h08;
  localparam logic [7:0] BIT_ENABLE    = 8'h04;
  localparam logic [7:0] BIT_SELECT    = 8'h01;
  localparam logic [7:0] NIBBLE_MASK   = 8'hF0;
  localparam logic [7:0] LINE2_BASE    = 8'h40;
  localparam logic [7:0] CMD_SET_ADDR  = 8'h80;
  localparam logic [7:0] DIGIT_ZERO    = 8'h30;

  localparam logic [6:0] ADDR_RESET = 7'd39;

  // Five decimal digits cover a 16-bit number.
  localparam int unsigned NUM_DIGITS = 5;
  localparam int unsigned DIG_IDX_W  = $clog2(NUM_DIGITS);
  localparam logic [DIG_IDX_W-1:0] DIG_LAST = DIG_IDX_W'(NUM_DIGITS - 1);

  // Reciprocal of ten: floor(x / 10) == (x * RECIP_TEN) >> RECIP_SHIFT for 16-bit x.
  localparam logic [16:0] RECIP_TEN   = 17'd52429;
  localparam int unsigned RECIP_SHIFT = 19;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] data_value;
    logic        row;
    logic [5:0]  col;
  } in_item_t;

  typedef struct packed {
    logic [7:0] expander_byte;
    logic [6:0] target_address;
    logic       starts_transfer;
    logic       ends_transfer;
    logic       last;
  } out_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic                 capture;
    logic                 conv;
    logic                 load;
    logic [DIG_IDX_W-1:0] idx;
    logic [1:0]           phase;
    logic                 last;
  } lcdw_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic [DIG_IDX_W-1:0] first_idx;
    logic                 out_free;
  } lcdw_sts_t;

endpackage

>>> rtl/lcdw_dp.sv
// Datapath: item capture, decimal digit extraction, expander byte formatting and output register.
module lcdw_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lcdw_pkg::in_item_t  in_i,
  input  logic                cfg_we_i,
  input  logic [6:0]          cfg_data_i,
  input  lcdw_pkg::lcdw_cmd_t cmd_i,
  output lcdw_pkg::lcdw_sts_t sts_o,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output lcdw_pkg::out_item_t out_o
);

  logic [6:0]  addr_q;
  logic [1:0]  mode_q;
  logic [7:0]  byte_q;
  logic [15:0] rem_q;
  logic [3:0]  dig_q [lcdw_pkg::NUM_DIGITS];
  logic        out_valid_q, out_valid_d;
  lcdw_pkg::out_item_t out_q, out_d;

  logic [32:0] prod;
  logic [15:0] quot;
  logic [15:0] tenfold;
  logic [3:0]  digit;
  logic [6:0]  cursor_sum;
  logic [7:0]  cur_byte;
  logic [7:0]  sel_bit;
  logic [7:0]  nibble;
  logic [7:0]  wr_byte;
  logic [lcdw_pkg::DIG_IDX_W-1:0] first_idx;

  // One decimal digit per step: quotient by reciprocal multiply, remainder by subtract.
  always_comb begin
    prod    = 33'(rem_q) * 33'(lcdw_pkg::RECIP_TEN);
    quot    = 16'(prod >> lcdw_pkg::RECIP_SHIFT);
    tenfold = 16'(quot << 3) + 16'(quot << 1);
    digit   = 4'(rem_q - tenfold);
  end

  assign cursor_sum = {in_i.row, 6'b0} + {1'b0, in_i.col};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= lcdw_pkg::ADDR_RESET;
    end else if (cfg_we_i) begin
      addr_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q <= in_i.mode;
      rem_q  <= in_i.data_value;
      if (in_i.mode == lcdw_pkg::MODE_CURSOR) begin
        byte_q <= lcdw_pkg::CMD_SET_ADDR | {1'b0, cursor_sum};
      end else begin
        byte_q <= in_i.data_value[7:0];
      end
    end else if (cmd_i.conv) begin
      rem_q <= quot;
      dig_q[cmd_i.idx] <= digit;
    end
  end

  // First digit to print: leading zeros dropped, the final digit always kept.
  always_comb begin
    if (dig_q[0] != 4'd0) begin
      first_idx = lcdw_pkg::DIG_IDX_W'(0);
    end else if (dig_q[1] != 4'd0) begin
      first_idx = lcdw_pkg::DIG_IDX_W'(1);
    end else if (dig_q[2] != 4'd0) begin
      first_idx = lcdw_pkg::DIG_IDX_W'(2);
    end else if (dig_q[3] != 4'd0) begin
      first_idx = lcdw_pkg::DIG_IDX_W'(3);
    end else begin
      first_idx = lcdw_pkg::DIG_LAST;
    end
  end

  // Expander write for the current byte and phase.
  always_comb begin
    if (mode_q == lcdw_pkg::MODE_NUMBER) begin
      cur_byte = lcdw_pkg::DIGIT_ZERO | {4'b0, dig_q[cmd_i.idx]};
    end else begin
      cur_byte = byte_q;
    end
    if (mode_q == lcdw_pkg::MODE_CHAR || mode_q == lcdw_pkg::MODE_NUMBER) begin
      sel_bit = lcdw_pkg::BIT_SELECT;
    end else begin
      sel_bit = 8'h00;
    end
    if (cmd_i.phase[1]) begin
      nibble = {cur_byte[3:0], 4'b0};
    end else begin
      nibble = cur_byte & lcdw_pkg::NIBBLE_MASK;
    end
    wr_byte = nibble | lcdw_pkg::BIT_BACKLIGHT | sel_bit;
    if (!cmd_i.phase[0]) begin
      wr_byte = wr_byte | lcdw_pkg::BIT_ENABLE;
    end
    out_d.expander_byte   = wr_byte;
    out_d.target_address  = addr_q;
    out_d.starts_transfer = (cmd_i.phase == 2'd0);
    out_d.ends_transfer   = (cmd_i.phase == 2'd3);
    out_d.last            = cmd_i.last;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_q <= out_d;
    end
  end

  assign sts_o.first_idx = first_idx;
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;
  assign out_valid_o     = out_valid_q;
  assign out_o           = out_q;

endmodule

>>> rtl/lcdw_ctrl.sv
// Controller: sequences item capture, digit conversion and the four writes of each byte.
module lcdw_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [1:0]          in_mode_i,
  output logic                in_stall_o,
  input  lcdw_pkg::lcdw_sts_t sts_i,
  output lcdw_pkg::lcdw_cmd_t cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_PICK = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]                     state_q, state_d;
  logic [lcdw_pkg::DIG_IDX_W-1:0] idx_q, idx_d;
  logic [1:0]                     phase_q, phase_d;
  logic                           accept;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    phase_d = phase_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          idx_d   = lcdw_pkg::DIG_LAST;
          phase_d = 2'd0;
          if (in_mode_i == lcdw_pkg::MODE_NUMBER) begin
            state_d = ST_CONV;
          end else begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_CONV: begin
        if (idx_q == '0) begin
          state_d = ST_PICK;
        end else begin
          idx_d = idx_q - 1'b1;
        end
      end
      ST_PICK: begin
        idx_d   = sts_i.first_idx;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          phase_d = phase_q + 2'd1;
          if (phase_q == 2'd3) begin
            if (idx_q == lcdw_pkg::DIG_LAST) begin
              state_d = ST_IDLE;
            end else begin
              idx_d = idx_q + 1'b1;
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      phase_q <= 2'd0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      phase_q <= phase_d;
    end
  end

  assign cmd_o.capture = accept;
  assign cmd_o.conv    = (state_q == ST_CONV);
  assign cmd_o.load    = (state_q == ST_EMIT) && sts_i.out_free;
  assign cmd_o.idx     = idx_q;
  assign cmd_o.phase   = phase_q;
  assign cmd_o.last    = (idx_q == lcdw_pkg::DIG_LAST) && (phase_q == 2'd3);

endmodule

>>> rtl/char_lcd_expander_writer.sv
// Top level of the character LCD expander writer: controller, datapath and checks.
//
//   Channel  Direction  Handshake                 Payload
//   in       input      in_valid_i / in_stall_o   in_i   (lcdw_pkg::in_item_t)
//   out      output     out_valid_o / out_stall_i out_o  (lcdw_pkg::out_item_t)
//   cfg      input      cfg_we_i                  cfg_data_i (device address)
//
// A command, character or cursor item is captured and then gives four expander
// writes. A number item is captured, passes through the divide-by-ten unit (one
// digit per cycle) for its five digits, then the first printed digit is found and
// each printed digit gives four expander writes.
// Reset clears the controller and the output valid flag and loads device address 39.
// A stall on the output holds the output register and pauses the write sequence;
// the next item is taken as soon as the last write has been loaded.
module char_lcd_expander_writer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  lcdw_pkg::in_item_t  in_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lcdw_pkg::out_item_t out_o,
  input  logic                cfg_we_i,
  input  logic [6:0]          cfg_data_i
);

  lcdw_pkg::lcdw_cmd_t cmd;
  lcdw_pkg::lcdw_sts_t sts;

  // The controller owns the sequencing: state, digit or byte index and write phase.
  lcdw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_mode_i  (in_i.mode),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // The datapath holds the captured item, the digit registers, the device address
  // and the output register, and forms each expander byte from the command fields.
  lcdw_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_o       (out_o)
  );

  // Once an item is taken the block is busy for at least the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken again right after an accepted item");

  // The final write of an item always closes a transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.last) |-> out_o.ends_transfer)
    else $error("last write does not end a transfer");

  // The first write of a transfer raises enable.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.starts_transfer) |-> out_o.expander_byte[2])
    else $error("transfer starts without enable set");

  // A write is only loaded when the output slot is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |-> (!out_valid_o || !out_stall_i))
    else $error("output register overwritten while stalled");

endmodule

>>> tb/sv/tb_char_lcd_expander_writer.sv
// Self-checking testbench of the character LCD expander writer with a write-stream scoreboard.
module tb_char_lcd_expander_writer;

  // Run limits. The slowest correct run is about 300 items of up to 20 writes,
  // each write waiting out the longest random stall, plus the long hold-off.
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned HOLD_CYCLES  = 160;
  localparam int unsigned PHASE_ITEMS  = 52;

  // The scoreboard holds the expander writes that accepted requests must produce,
  // in order, together with its own copy of the device address register.
  class lcd_write_scoreboard;
    lcdw_pkg::out_item_t pending_writes[$];
    logic [6:0]  dev_addr;
    int unsigned errors;

    function new();
      dev_addr = lcdw_pkg::ADDR_RESET;
      errors   = 0;
    endfunction

    function void set_address(logic [6:0] addr);
      dev_addr = addr;
    endfunction

    // One display byte becomes four writes: high nibble with and without enable,
    // then low nibble with and without enable.
    function void queue_display_byte(logic [7:0] value, logic [7:0] sel, bit final_byte);
      logic [7:0] hi;
      logic [7:0] lo;
      logic [7:0] seq [4];
      lcdw_pkg::out_item_t w;
      hi = (value & lcdw_pkg::NIBBLE_MASK) | lcdw_pkg::BIT_BACKLIGHT | sel;
      lo = ((value << 4) & lcdw_pkg::NIBBLE_MASK) | lcdw_pkg::BIT_BACKLIGHT | sel;
      seq[0] = hi | lcdw_pkg::BIT_ENABLE;
      seq[1] = hi & ~lcdw_pkg::BIT_ENABLE;
      seq[2] = lo | lcdw_pkg::BIT_ENABLE;
      seq[3] = lo & ~lcdw_pkg::BIT_ENABLE;
      for (int i = 0; i < 4; i++) begin
        w.expander_byte   = seq[i];
        w.target_address  = dev_addr;
        w.starts_transfer = (i == 0);
        w.ends_transfer   = (i == 3);
        w.last            = final_byte && (i == 3);
        pending_writes.push_back(w);
      end
    endfunction

    function void note_request(lcdw_pkg::in_item_t req);
      logic [7:0]  digit [5];
      int unsigned v;
      int          first;
      logic [7:0]  base;
      case (req.mode)
        lcdw_pkg::MODE_CMD:  queue_display_byte(req.data_value[7:0], 8'h00, 1'b1);
        lcdw_pkg::MODE_CHAR: queue_display_byte(req.data_value[7:0], lcdw_pkg::BIT_SELECT, 1'b1);
        lcdw_pkg::MODE_NUMBER: begin
          v = 32'(req.data_value);
          for (int i = 4; i >= 0; i--) begin
            digit[i] = lcdw_pkg::DIGIT_ZERO + 8'(v % 10);
            v = v / 10;
          end
          // Leading zeros are dropped, but the units digit always prints.
          first = 0;
          while (first < 4 && digit[first] == lcdw_pkg::DIGIT_ZERO) first++;
          for (int i = first; i < 5; i++) begin
            queue_display_byte(digit[i], lcdw_pkg::BIT_SELECT, i == 4);
          end
        end
        default: begin
          base = req.row ? lcdw_pkg::LINE2_BASE : 8'h00;
          queue_display_byte(lcdw_pkg::CMD_SET_ADDR | (base + {2'b00, req.col}), 8'h00, 1'b1);
        end
      endcase
    endfunction

    function void compare_field(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
        errors++;
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_write(lcdw_pkg::out_item_t got);
      lcdw_pkg::out_item_t exp_w;
      if (pending_writes.size() == 0) begin
        errors++;
        $display("%0t: unexpected write, expected none, actual 0x%0h", $time, got);
        return;
      end
      exp_w = pending_writes.pop_front();
      compare_field("expander_byte", 32'(exp_w.expander_byte), 32'(got.expander_byte));
      compare_field("target_address", 32'(exp_w.target_address), 32'(got.target_address));
      compare_field("starts_transfer", 32'(exp_w.starts_transfer), 32'(got.starts_transfer));
      compare_field("ends_transfer", 32'(exp_w.ends_transfer), 32'(got.ends_transfer));
      compare_field("last", 32'(exp_w.last), 32'(got.last));
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  lcdw_pkg::in_item_t  in_i;
  logic        out_valid_o;
  logic        out_stall_i;
  lcdw_pkg::out_item_t out_o;
  logic        cfg_we_i;
  logic [6:0]  cfg_data_i;

  lcd_write_scoreboard sb;
  int unsigned cycle_count;
  int unsigned idle_burst_left;
  bit          hold_off_req;

  char_lcd_expander_writer i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Both handshakes are sampled at the rising edge. All inputs are driven at
  // the falling edge, so nothing here races with the block's own registers.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_request(in_i);
      if (out_valid_o && !out_stall_i) sb.check_write(out_o);
    end
  end

  // Receiver stall pattern: calm stretches, short stalls, a few long ones, and
  // on request one long hold-off so that the block fills up and stalls its input.
  initial begin
    int unsigned stall_left;
    int unsigned calm_left;
    int unsigned r;
    out_stall_i = 1'b0;
    stall_left  = 0;
    calm_left   = 0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall_i  = 1'b1;
        stall_left   = HOLD_CYCLES;
      end else if (stall_left > 0) begin
        stall_left--;
      end else if (calm_left > 0) begin
        out_stall_i = 1'b0;
        calm_left--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          out_stall_i = 1'b0;
          calm_left   = $urandom_range(20, 80);
        end else if (r < 40) begin
          out_stall_i = 1'b1;
          stall_left  = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                    : $urandom_range(0, 2);
        end else begin
          out_stall_i = 1'b0;
        end
      end
    end
  end

  // Sender gap: usually none or short, sometimes long, with gap-free bursts.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (idle_burst_left > 0) begin
      idle_burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 6) begin
      idle_burst_left = $urandom_range(8, 25);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance with
  // valid still high, so back-to-back items need no extra assignment.
  task automatic send_request(lcdw_pkg::in_item_t req);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_i       = req;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic send_fields(logic [1:0] mode, logic [15:0] dv, logic row, logic [5:0] col);
    lcdw_pkg::in_item_t req;
    req.mode       = mode;
    req.data_value = dv;
    req.row        = row;
    req.col        = col;
    send_request(req);
  endtask

  // Stop offering items and wait until every expected write has arrived, then
  // let the block settle for its latency.
  task automatic drain_block();
    in_valid_i = 1'b0;
    while (sb.pending_writes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // The address register is only written while the block is idle.
  task automatic program_address(logic [6:0] addr);
    drain_block();
    cfg_data_i = addr;
    cfg_we_i   = 1'b1;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.set_address(addr);
  endtask

  // Random requests: numbers lean toward short values and decade boundaries so
  // that every digit count shows up; the rest are full 16-bit values.
  function automatic lcdw_pkg::in_item_t random_request();
    lcdw_pkg::in_item_t req;
    int unsigned pow10;
    req.mode = 2'($urandom_range(0, 3));
    req.row  = 1'($urandom_range(0, 1));
    req.col  = 6'($urandom_range(0, 63));
    case ($urandom_range(0, 3))
      0: req.data_value = 16'($urandom_range(0, 65535));
      1: req.data_value = 16'($urandom_range(0, 9));
      2: req.data_value = 16'($urandom_range(0, 999));
      default: begin
        pow10 = 1;
        repeat ($urandom_range(1, 4)) pow10 = pow10 * 10;
        req.data_value = 16'(pow10 - $urandom_range(0, 1));
      end
    endcase
    return req;
  endfunction

  task automatic run_random_phase(int unsigned count, bit with_hold_off);
    for (int unsigned i = 0; i < count; i++) begin
      // The hold-off starts while the sender keeps offering items.
      if (with_hold_off && i == 4) hold_off_req = 1'b1;
      send_request(random_request());
    end
  endtask

  initial begin
    logic [6:0] addr_list [5];
    sb              = new();
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    in_i            = '0;
    cfg_we_i        = 1'b0;
    cfg_data_i      = '0;
    idle_burst_left = 0;
    hold_off_req    = 1'b0;
    addr_list[0] = 7'h00;
    addr_list[1] = 7'h7F;
    addr_list[2] = 7'h55;
    addr_list[3] = 7'h2A;
    addr_list[4] = 7'($urandom_range(1, 126));

    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part at the reset address. Commands and characters ignore the
    // upper byte, the cursor ignores the value, and the others ignore row and col.
    send_fields(lcdw_pkg::MODE_CMD, 16'h0000, 1'b0, 6'd0);
    send_fields(lcdw_pkg::MODE_CMD, 16'hAB_FF, 1'b1, 6'd63);
    send_fields(lcdw_pkg::MODE_CHAR, 16'h0041, 1'b0, 6'd0);
    send_fields(lcdw_pkg::MODE_CHAR, 16'hFF00, 1'b1, 6'd21);
    send_fields(lcdw_pkg::MODE_CHAR, 16'h5AFF, 1'b0, 6'd0);
    // Zero prints as a single digit; the others cover every digit count.
    send_fields(lcdw_pkg::MODE_NUMBER, 16'd0, 1'b1, 6'd63);
    send_fields(lcdw_pkg::MODE_NUMBER, 16'd9, 1'b0, 6'd0);
    send_fields(lcdw_pkg::MODE_NUMBER, 16'd10, 1'b0, 6'd0);
    send_fields(lcdw_pkg::MODE_NUMBER, 16'd99, 1'b0, 6'd0);
    send_fields(lcdw_pkg::MODE_NUMBER, 16'd100, 1'b0, 6'd0);
    send_fields(lcdw_pkg::MODE_NUMBER, 16'd1000, 1'b0, 6'd0);
    send_fields(lcdw_pkg::MODE_NUMBER, 16'd9999, 1'b0, 6'd0);
    send_fields(lcdw_pkg::MODE_NUMBER, 16'd10000, 1'b0, 6'd0);
    send_fields(lcdw_pkg::MODE_NUMBER, 16'd65535, 1'b0, 6'd0);
    send_fields(lcdw_pkg::MODE_NUMBER, 16'd10203, 1'b0, 6'd0);
    // Cursor moves, including columns beyond the visible display.
    send_fields(lcdw_pkg::MODE_CURSOR, 16'hFFFF, 1'b0, 6'd0);
    send_fields(lcdw_pkg::MODE_CURSOR, 16'h0000, 1'b1, 6'd0);
    send_fields(lcdw_pkg::MODE_CURSOR, 16'h1234, 1'b1, 6'd39);
    send_fields(lcdw_pkg::MODE_CURSOR, 16'h0000, 1'b0, 6'd63);
    send_fields(lcdw_pkg::MODE_CURSOR, 16'h8000, 1'b1, 6'd63);

    // Random phases, each under a different device address. The second phase
    // carries the long receiver hold-off.
    for (int p = 0; p < 5; p++) begin
      program_address(addr_list[p]);
      run_random_phase(PHASE_ITEMS, p == 1);
    end

    drain_block();
    if (sb.errors == 0) begin
      $display("** char_lcd_expander_writer: PASSED **");
    end else begin
      $display("** char_lcd_expander_writer: FAILED **");
    end
    $finish;
  end

  // Watchdog: a run that has not ended by the limit counts as failed.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("** char_lcd_expander_writer: FAILED **");
    $finish;
  end

endmodule

>>> filelist.f
rtl/lcdw_pkg.sv
rtl/lcdw_dp.sv
rtl/lcdw_ctrl.sv
rtl/char_lcd_expander_writer.sv
tb/sv/tb_char_lcd_expander_writer.sv
